// ===== hdl/htspc_pkg.sv =====
// Shared types and codes for the humidity/temperature sensor poll controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package htspc_pkg;

	// Result codes
	localparam logic [1:0] RC_OK          = 2'd0;
	localparam logic [1:0] RC_NOT_PRESENT = 2'd1;
	localparam logic [1:0] RC_SERVICE     = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_CONV_TIME = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
	localparam logic [1:0] CFG_ERR_LIMIT = 2'd2;

	localparam logic [15:0] CONV_TIME_RST = 16'd80;
	localparam logic [15:0] TIMEOUT_RST   = 16'd500;
	localparam logic [15:0] ERR_LIMIT_RST = 16'd5;

	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 56;

	// Raw call as captured from the slave side
	typedef struct packed {
		logic        func;
		logic [31:0] now_ms;
		logic        probe_ok;
		logic [7:0]  status_byte;
		logic        init_ack;
		logic        trigger_ack;
		logic        frame_ok;
		logic [55:0] frame;
	} call_t;

	// Call with the frame already checked and scaled
	typedef struct packed {
		logic               func;
		logic [31:0]        now_ms;
		logic               probe_ok;
		logic               calibrated;
		logic               init_ack;
		logic               trigger_ack;
		logic               frame_good;
		logic [13:0]        humidity;
		logic signed [14:0] temperature;
	} dec_t;

	// One result beat
	typedef struct packed {
		logic [15:0]        error_count;
		logic               available;
		logic signed [14:0] temperature_centi;
		logic [13:0]        humidity_centi;
		logic               has_reading;
		logic               frame_read;
		logic               trigger_issued;
		logic [1:0]         result_code;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/htspc_frame_dec.sv =====
// Frame check (CRC8 poly 0x31, init 0xFF, busy bit) and fixed-point scaling stage.
// Depends on htspc_pkg; holds the second pipeline register.
`default_nettype none

module htspc_frame_dec (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  htspc_pkg::call_t     in_call,
	output logic                 out_valid,
	input  wire                  out_ready,
	output htspc_pkg::dec_t      out_dec
);
	import htspc_pkg::*;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	logic [7:0]  crc;
	logic [19:0] raw_h;
	logic [19:0] raw_t;
	logic [33:0] h_prod;
	logic [34:0] t_prod;
	logic [14:0] t_scaled;
	logic        good;
	dec_t        dec_d;
	dec_t        dec_s2;
	logic        valid_s2;

	always_comb begin
		crc = CRC_INIT;
		for (int i = 0; i < 6; i++) begin
			crc = crc8_byte(crc, in_call.frame[55 - 8*i -: 8]);
		end
	end

	assign raw_h    = in_call.frame[47:28];
	assign raw_t    = in_call.frame[27:8];
	assign h_prod   = 34'(raw_h) * 34'd10000;
	assign t_prod   = 35'(raw_t) * 35'd20000;
	assign t_scaled = t_prod[34:20];
	assign good     = in_call.frame_ok && !in_call.frame[55] && (crc == in_call.frame[7:0]);

	always_comb begin
		dec_d.func        = in_call.func;
		dec_d.now_ms      = in_call.now_ms;
		dec_d.probe_ok    = in_call.probe_ok;
		dec_d.calibrated  = in_call.status_byte[3];
		dec_d.init_ack    = in_call.init_ack;
		dec_d.trigger_ack = in_call.trigger_ack;
		dec_d.frame_good  = good;
		dec_d.humidity    = h_prod[33:20];
		dec_d.temperature = $signed(t_scaled - 15'd5000);
	end

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_dec   = dec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dec_s2 <= dec_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/htspc_ctrl.sv =====
// Controller state, configuration registers and result register.
// Depends on htspc_pkg; fed by htspc_frame_dec.
`default_nettype none

module htspc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [1:0]            cfg_index,
	input  wire [15:0]           cfg_data,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  htspc_pkg::dec_t      in_dec,
	output logic                 out_valid,
	input  wire                  out_ready,
	output htspc_pkg::result_t   out_res
);
	import htspc_pkg::*;

	typedef enum logic [2:0] {
		PH_UNINIT = 3'b001,
		PH_IDLE   = 3'b010,
		PH_MEAS   = 3'b100
	} phase_t;

	logic [15:0] conv_time_q, timeout_q, err_limit_q;

	phase_t             phase_q, phase_d;
	logic [31:0]        trig_time_q, trig_time_d;
	logic [31:0]        last_svc_q, last_svc_d;
	logic               serviced_q, serviced_d;
	logic               reading_q, reading_d;
	logic               avail_q, avail_d;
	logic [15:0]        errors_q, errors_d;
	logic [13:0]        hum_q, hum_d;
	logic signed [14:0] temp_q, temp_d;

	logic [1:0]  code;
	logic        trig, rd;
	logic [31:0] elapsed;
	logic        fire;
	logic        out_v_q;
	result_t     res_q;

	assign in_ready  = !out_v_q || out_ready;
	assign fire      = in_valid && in_ready;
	assign elapsed   = in_dec.now_ms - trig_time_q;
	assign out_valid = out_v_q;
	assign out_res   = res_q;

	always_comb begin
		phase_d     = phase_q;
		trig_time_d = trig_time_q;
		last_svc_d  = last_svc_q;
		serviced_d  = serviced_q;
		reading_d   = reading_q;
		avail_d     = avail_q;
		errors_d    = errors_q;
		hum_d       = hum_q;
		temp_d      = temp_q;
		code        = RC_SERVICE;
		trig        = 1'b0;
		rd          = 1'b0;

		if (!in_dec.func) begin
			code = RC_OK;
			if (!avail_q) begin
				phase_d    = PH_UNINIT;
				reading_d  = 1'b0;
				serviced_d = 1'b0;
				errors_d   = '0;
				if (!in_dec.probe_ok) begin
					code = RC_NOT_PRESENT;
				end else if (!in_dec.calibrated && !in_dec.init_ack) begin
					code = RC_NOT_PRESENT;
				end else begin
					avail_d = 1'b1;
					trig    = 1'b1;
					if (!in_dec.trigger_ack) begin
						errors_d = 16'd1;
						if (errors_d == err_limit_q) begin
							avail_d = 1'b0;
						end
						phase_d = PH_IDLE;
					end else begin
						trig_time_d = '0;
						phase_d     = PH_MEAS;
					end
				end
			end
		end else if (avail_q && phase_q != PH_UNINIT &&
				!(serviced_q && in_dec.now_ms == last_svc_q)) begin
			last_svc_d = in_dec.now_ms;
			serviced_d = 1'b1;
			if (phase_q != PH_MEAS) begin
				trig = 1'b1;
				if (!in_dec.trigger_ack) begin
					if (errors_q != 16'hFFFF) begin
						errors_d = errors_q + 16'd1;
					end
					if (errors_d == err_limit_q) begin
						avail_d = 1'b0;
					end
					phase_d = PH_IDLE;
				end else begin
					trig_time_d = in_dec.now_ms;
					phase_d     = PH_MEAS;
				end
			end else if (elapsed >= 32'(conv_time_q)) begin
				rd = 1'b1;
				if (in_dec.frame_good) begin
					hum_d     = in_dec.humidity;
					temp_d    = in_dec.temperature;
					reading_d = 1'b1;
					trig      = 1'b1;
					// errors were just cleared, so a failed trigger leaves one
					if (!in_dec.trigger_ack) begin
						errors_d = 16'd1;
						if (errors_d == err_limit_q) begin
							avail_d = 1'b0;
						end
						phase_d = PH_IDLE;
					end else begin
						errors_d    = '0;
						trig_time_d = in_dec.now_ms;
						phase_d     = PH_MEAS;
					end
				end else if (elapsed >= 32'(timeout_q)) begin
					if (errors_q != 16'hFFFF) begin
						errors_d = errors_q + 16'd1;
					end
					if (errors_d == err_limit_q) begin
						avail_d = 1'b0;
					end
					phase_d = PH_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_time_q <= CONV_TIME_RST;
			timeout_q   <= TIMEOUT_RST;
			err_limit_q <= ERR_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CONV_TIME: conv_time_q <= cfg_data;
				CFG_TIMEOUT:   timeout_q   <= cfg_data;
				CFG_ERR_LIMIT: err_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_UNINIT;
			trig_time_q <= '0;
			last_svc_q  <= '0;
			serviced_q  <= 1'b0;
			reading_q   <= 1'b0;
			avail_q     <= 1'b0;
			errors_q    <= '0;
			hum_q       <= '0;
			temp_q      <= '0;
			out_v_q     <= 1'b0;
		end else begin
			if (fire) begin
				phase_q     <= phase_d;
				trig_time_q <= trig_time_d;
				last_svc_q  <= last_svc_d;
				serviced_q  <= serviced_d;
				reading_q   <= reading_d;
				avail_q     <= avail_d;
				errors_q    <= errors_d;
				hum_q       <= hum_d;
				temp_q      <= temp_d;
			end
			if (in_ready) begin
				out_v_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.result_code       <= code;
			res_q.trigger_issued    <= trig;
			res_q.frame_read        <= rd;
			res_q.has_reading       <= reading_d;
			res_q.humidity_centi    <= hum_d;
			res_q.temperature_centi <= temp_d;
			res_q.available         <= avail_d;
			res_q.error_count       <= errors_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/humidity_temp_sensor_poll_controller_top.sv =====
// Top level of the humidity/temperature sensor poll controller.
// Depends on htspc_pkg, htspc_frame_dec and htspc_ctrl.
//
// Usage:
//   Slave stream: one beat per begin or service call. s_tuser carries the call
//   kind (0 begin, 1 service); s_tdata carries the bus outcomes of that call.
//   Master stream: exactly one result beat per call, in call order.
//   Config port: cfg_we/cfg_index/cfg_data write conversion time (0), measure
//   timeout (1) and error limit (2); write only while no call is in flight.
//   Path: an accepted beat passes three registers (input register, frame
//   check/scaling, controller step), the first of which loads at the accepting
//   edge. Throughput: one beat per cycle while m_tready is high; the
//   controller state is updated as each beat is taken, so back-to-back calls
//   see each other's effects in order.
//   The frame CRC and the humidity/temperature multiplies sit in the middle
//   stage and set the critical path there.
//   Reset: arst_n clears all flags, error count and stored readings to zero,
//   sets the sensor uninitialized and loads the config registers with
//   80 / 500 / 5. No clearing pass is needed; beats are taken at once.
//   Stall: when m_tready is low the result is held; earlier stages keep
//   filling until each holds a beat, then s_tready drops.
`default_nettype none

module humidity_temp_sensor_poll_controller_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// [31:0] now_ms, [32] probe_ok, [40:33] status_byte, [41] init_ack,
	// [42] trigger_ack, [43] frame_ok, [99:44] frame, [103:100] zero
	input  wire [103:0] s_tdata,
	// [0] func
	input  wire         s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// [1:0] result_code, [2] trigger_issued, [3] frame_read, [4] has_reading,
	// [18:5] humidity_centi, [33:19] temperature_centi, [34] available,
	// [50:35] error_count, [55:51] zero
	output logic [55:0] m_tdata,
	input  wire         cfg_we,
	input  wire [1:0]   cfg_index,
	input  wire [15:0]  cfg_data
);
	import htspc_pkg::*;

	call_t   call_d, call_s1;
	logic    valid_s1;
	logic    dec_ready;
	logic    dec_valid;
	dec_t    dec;
	logic    ctrl_ready;
	result_t res;

	// unpack the slave beat
	always_comb begin
		call_d.func        = s_tuser;
		call_d.now_ms      = s_tdata[31:0];
		call_d.probe_ok    = s_tdata[32];
		call_d.status_byte = s_tdata[40:33];
		call_d.init_ack    = s_tdata[41];
		call_d.trigger_ack = s_tdata[42];
		call_d.frame_ok    = s_tdata[43];
		call_d.frame       = s_tdata[99:44];
	end

	// input register: advance when the next stage can take its beat
	assign s_tready = !valid_s1 || dec_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			call_s1 <= call_d;
		end
	end

	htspc_frame_dec u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (dec_ready),
		.in_call   (call_s1),
		.out_valid (dec_valid),
		.out_ready (ctrl_ready),
		.out_dec   (dec)
	);

	htspc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (dec_valid),
		.in_ready  (ctrl_ready),
		.in_dec    (dec),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// pack the result beat, zero fill to whole bytes
	assign m_tdata = {5'b0, res};

endmodule

`default_nettype wire

// ===== hdl/htspc_checker.sv =====
// Port-level checks for the sensor poll controller, bound to the top level.
// Depends on htspc_pkg and humidity_temp_sensor_poll_controller_top.
`default_nettype none

module htspc_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [55:0]  m_tdata
);
	import htspc_pkg::*;

	// hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] == RC_OK || m_tdata[1:0] == RC_NOT_PRESENT ||
			m_tdata[1:0] == RC_SERVICE)
		else $error("undefined result code");

	// a failed begin leaves the sensor down with a clean error count
	a_not_present: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == RC_NOT_PRESENT |->
			!m_tdata[34] && !m_tdata[2] && m_tdata[50:35] == 16'd0 && !m_tdata[4])
		else $error("not-present result with live sensor state");

	// frames are only read by service calls
	a_read_service: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[1:0] == RC_SERVICE)
		else $error("frame read outside a service call");

endmodule

bind humidity_temp_sensor_poll_controller_top htspc_checker u_htspc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
